### design/fud_pkg.sv
// Package for the form-urlencoded decoder: word types, character codes, hex decode.
package fud_pkg;

    localparam int MAX_PAIRS_DEFAULT = 255;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0]  CHAR_EQ    = 8'h3D;
    localparam logic [7:0]  CHAR_AMP   = 8'h26;
    localparam logic [7:0]  CHAR_PCT   = 8'h25;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [15:0] LEN_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  out_char;
        logic        in_value;
        logic        key_end;
        logic        value_end;
        logic [15:0] field_length;
        logic [7:0]  pair_index;
        logic        out_last;
    } out_word_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       is_eq;
        logic       is_amp;
        logic       is_pct;
        logic       is_plus;
        logic       hex_ok;
        logic [3:0] hex_digit;
    } cls_word_t;

    // {ok, digit}; digit is 0 when the character is not hex
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b0_0000;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

### design/fud_stream_if.sv
// Valid/ready stream interface carrying one payload word per handshake.
interface fud_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/form_urlencoded_decoder.sv
// Form-urlencoded decoder: raw query bytes in, one decoded result word out per byte.
// Sustains one byte per clock while the output side is ready; each input word yields
// exactly one output word, registered first in the queue and then in the output
// register. The front classifies each byte (separators, percent, plus, hex digit)
// into a two-word queue; the back updates key/value mode, escape phase, field length
// and pair count for each word and holds the result in an output register, so input
// and output stall independently. in.ready drops only when the queue is full. The pair
// index saturates at the lesser of MAX_PAIRS and 255; all state clears after a word
// marked last.
module form_urlencoded_decoder #(
    parameter int MAX_PAIRS = fud_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    fud_stream_if.sink   in,
    fud_stream_if.source out
);
    import fud_pkg::*;

    cls_word_t push_word, pop_word;
    logic      push, full, pop, q_valid;

    fud_front u_front (
        .in     (in),
        .q_full (full),
        .q_push (push),
        .q_word (push_word)
    );

    fud_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_word  (push_word),
        .full     (full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_word  (pop_word)
    );

    fud_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (pop_word),
        .q_pop   (pop),
        .out     (out)
    );

endmodule

### design/fud_front.sv
// Front end: accepts raw bytes and classifies them into queue words.
module fud_front (
    fud_stream_if.sink          in,
    input  logic                q_full,
    output logic                q_push,
    output fud_pkg::cls_word_t  q_word
);
    import fud_pkg::*;

    logic [4:0] hex;

    assign in.ready = !q_full;
    assign q_push   = in.valid && !q_full;

    always_comb
    begin
        hex               = hex_decode(in.payload.in_byte);
        q_word.raw        = in.payload.in_byte;
        q_word.last       = in.payload.in_last;
        q_word.is_eq      = (in.payload.in_byte == CHAR_EQ);
        q_word.is_amp     = (in.payload.in_byte == CHAR_AMP);
        q_word.is_pct     = (in.payload.in_byte == CHAR_PCT);
        q_word.is_plus    = (in.payload.in_byte == CHAR_PLUS);
        q_word.hex_ok     = hex[4];
        q_word.hex_digit  = hex[3:0];
    end

endmodule

### design/fud_queue.sv
// Short FIFO of classified words between front and back.
module fud_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fud_pkg::cls_word_t  wr_word,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output fud_pkg::cls_word_t  rd_word
);
    import fud_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cls_word_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

### design/fud_back.sv
// Back end: key/value and escape state, result formation, output register.
module fud_back #(
    parameter int MAX_PAIRS = fud_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fud_pkg::cls_word_t  q_word,
    output logic                q_pop,
    fud_stream_if.source        out
);
    import fud_pkg::*;

    localparam logic [7:0] PAIR_CAP = (MAX_PAIRS > 255) ? 8'd255 : 8'(MAX_PAIRS);

    logic        value_mode_reg, value_mode_next;
    esc_phase_t  phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        high_ok_reg, high_ok_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  pair_reg, pair_next;
    logic        out_valid_reg;
    out_word_t   out_word_reg, res;

    logic sep, esc;
    logic cv, kend, vend;
    logic [7:0]  ch;
    logic [15:0] flen, len_mid;
    logic        vm_mid;

    assign q_pop       = q_valid && (!out_valid_reg || out.ready);
    assign out.valid   = out_valid_reg;
    assign out.payload = out_word_reg;

    assign sep = q_word.is_amp || (q_word.is_eq && !value_mode_reg);

    // escape sequencer: next phase
    always_comb
    begin
        phase_next = ESC_NONE;
        if (!sep && !q_word.last)
        begin
            case (phase_reg)
                ESC_HIGH: phase_next = ESC_LOW;
                ESC_LOW:  phase_next = ESC_NONE;
                default:  phase_next = q_word.is_pct ? ESC_HIGH : ESC_NONE;
            endcase
        end
    end

    // result and data state
    always_comb
    begin
        esc              = (phase_reg == ESC_HIGH) || (phase_reg == ESC_LOW);
        cv               = 1'b0;
        ch               = 8'h00;
        kend             = 1'b0;
        vend             = 1'b0;
        flen             = 16'h0000;
        vm_mid           = value_mode_reg;
        len_mid          = length_reg;
        pair_next        = pair_reg;
        high_nibble_next = high_nibble_reg;
        high_ok_next     = high_ok_reg;

        if (sep)
        begin
            flen    = length_reg;
            len_mid = 16'h0000;
            if (q_word.is_eq)
            begin
                kend   = 1'b1;
                vm_mid = 1'b1;
            end
            else
            begin
                kend   = !value_mode_reg;
                vend   = 1'b1;
                vm_mid = 1'b0;
                if (pair_reg < PAIR_CAP)
                    pair_next = pair_reg + 1'b1;
            end
        end
        else if (esc)
        begin
            if (phase_reg == ESC_HIGH)
            begin
                high_ok_next     = q_word.hex_ok;
                high_nibble_next = q_word.hex_digit;
            end
            else
            begin
                cv = 1'b1;
                if (!high_ok_reg)
                    ch = 8'h00;
                else if (q_word.hex_ok)
                    ch = {high_nibble_reg, q_word.hex_digit};
                else
                    ch = {4'h0, high_nibble_reg};
            end
        end
        else if (!q_word.is_pct)
        begin
            cv = 1'b1;
            ch = q_word.is_plus ? CHAR_SPACE : q_word.raw;
        end

        if (cv && (len_mid != LEN_MAX))
            len_mid = len_mid + 1'b1;

        value_mode_next = vm_mid;
        length_next     = len_mid;

        // end of string closes the open field and clears all state
        if (q_word.last)
        begin
            if (!vend)
            begin
                if (vm_mid)
                begin
                    vend = 1'b1;
                    if (!kend)
                        flen = len_mid;
                end
                else
                begin
                    kend = 1'b1;
                    vend = 1'b1;
                    flen = len_mid;
                end
            end
            value_mode_next  = 1'b0;
            length_next      = 16'h0000;
            pair_next        = 8'h00;
            high_nibble_next = 4'h0;
            high_ok_next     = 1'b0;
        end

        res.char_valid   = cv;
        res.out_char     = ch;
        res.in_value     = value_mode_reg;
        res.key_end      = kend;
        res.value_end    = vend;
        res.field_length = flen;
        res.pair_index   = pair_reg;
        res.out_last     = q_word.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_mode_reg  <= 1'b0;
            phase_reg       <= ESC_NONE;
            high_nibble_reg <= 4'h0;
            high_ok_reg     <= 1'b0;
            length_reg      <= 16'h0000;
            pair_reg        <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                value_mode_reg  <= value_mode_next;
                phase_reg       <= phase_next;
                high_nibble_reg <= high_nibble_next;
                high_ok_reg     <= high_ok_next;
                length_reg      <= length_next;
                pair_reg        <= pair_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_word_reg <= res;
    end

    a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_word_reg.field_length != 16'h0000)
            |-> (out_word_reg.key_end || out_word_reg.value_end))
        else $error("field_length set without a field end");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.char_valid |-> (out_word_reg.out_char == 8'h00))
        else $error("out_char nonzero without char_valid");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_word.last
            |=> (pair_reg == 8'h00) && !value_mode_reg && (phase_reg == ESC_NONE)
                && (length_reg == 16'h0000))
        else $error("state not cleared after end of string");

    a_pair_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pair_reg <= PAIR_CAP)
        else $error("pair count beyond cap");

endmodule

### tb/sv/form_urlencoded_decoder_tb.sv
// Self-checking testbench for the form-urlencoded decoder: directed and random query strings.
module form_urlencoded_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fud_pkg::*;

    localparam logic [7:0] PAIR_CAP  = (MAX_PAIRS_DEFAULT > 255) ? 8'd255 : 8'(MAX_PAIRS_DEFAULT);
    localparam string      HEX_CHARS = "0123456789abcdefABCDEF";

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fud_stream_if #(.payload_t(in_word_t))  in_if ();
    fud_stream_if #(.payload_t(out_word_t)) out_if ();

    logic     in_valid_d  = 1'b0;
    in_word_t in_word_d   = '0;
    logic     out_ready_d = 1'b0;

    assign in_if.valid   = in_valid_d;
    assign in_if.payload = in_word_d;
    assign out_if.ready  = out_ready_d;

    form_urlencoded_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if)
    );

    always #5 clk = ~clk;

    // decoder state as predicted
    logic       mode_q;
    esc_phase_t esc_q;
    logic [3:0] hi_q;
    logic       hi_ok_q;
    logic [15:0] len_q;
    logic [7:0] pairs_q;

    out_word_t  decoded_q[$];
    logic [7:0] pend_q[$];
    int         fail_cnt      = 0;
    int         bytes_sent    = 0;
    int         in_idle_pct   = 10;
    int         out_stall_pct = 10;

    function automatic void clear_decoder();
        mode_q  = 1'b0;
        esc_q   = ESC_NONE;
        hi_q    = 4'h0;
        hi_ok_q = 1'b0;
        len_q   = 16'h0;
        pairs_q = 8'h0;
    endfunction

    function automatic out_word_t decode_byte(input in_word_t w);
        out_word_t  r;
        logic       is_sep;
        logic       d_ok;
        logic [7:0] d;
        r = '0;
        r.in_value   = mode_q;
        r.pair_index = pairs_q;
        r.out_last   = w.in_last;
        is_sep = (w.in_byte == CHAR_AMP) || (w.in_byte == CHAR_EQ && !mode_q);
        d_ok = 1'b1;
        d    = 8'h0;
        if (w.in_byte >= "0" && w.in_byte <= "9")
            d = w.in_byte - "0";
        else if (w.in_byte >= "a" && w.in_byte <= "f")
            d = w.in_byte - "a" + 8'd10;
        else if (w.in_byte >= "A" && w.in_byte <= "F")
            d = w.in_byte - "A" + 8'd10;
        else
            d_ok = 1'b0;

        if (is_sep)
        begin
            esc_q = ESC_NONE;
            if (w.in_byte == CHAR_EQ)
            begin
                r.key_end      = 1'b1;
                r.field_length = len_q;
                mode_q         = 1'b1;
            end
            else
            begin
                if (!mode_q)
                    r.key_end = 1'b1;
                r.value_end    = 1'b1;
                r.field_length = len_q;
                mode_q         = 1'b0;
                if (pairs_q < PAIR_CAP)
                    pairs_q = pairs_q + 8'd1;
            end
            len_q = 16'h0;
        end
        else if (esc_q == ESC_HIGH)
        begin
            hi_ok_q = d_ok;
            hi_q    = d_ok ? d[3:0] : 4'h0;
            esc_q   = ESC_LOW;
        end
        else if (esc_q == ESC_LOW)
        begin
            // strtol rules: bad first digit -> 0, bad second -> first digit alone
            if (!hi_ok_q)
                r.out_char = 8'h00;
            else if (d_ok)
                r.out_char = {hi_q, d[3:0]};
            else
                r.out_char = {4'h0, hi_q};
            r.char_valid = 1'b1;
            esc_q        = ESC_NONE;
        end
        else
        begin
            esc_q = ESC_NONE;
            if (w.in_byte == CHAR_PCT)
                esc_q = ESC_HIGH;
            else
            begin
                r.out_char   = (w.in_byte == CHAR_PLUS) ? CHAR_SPACE : w.in_byte;
                r.char_valid = 1'b1;
            end
        end

        if (r.char_valid && len_q != LEN_MAX)
            len_q = len_q + 16'd1;

        if (w.in_last)
        begin
            // close the open field; a trailing '&' already closed the pair
            if (!r.value_end)
            begin
                if (mode_q)
                begin
                    r.value_end = 1'b1;
                    if (!r.key_end)
                        r.field_length = len_q;
                end
                else
                begin
                    r.key_end      = 1'b1;
                    r.value_end    = 1'b1;
                    r.field_length = len_q;
                end
            end
            clear_decoder();
        end
        return r;
    endfunction

    initial clear_decoder();

    always @(negedge clk)
        out_ready_d <= ($urandom_range(99) >= out_stall_pct);

    // result check first, then prediction of the word accepted at this edge
    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t got;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                got = out_if.payload;
                if (decoded_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result word: %p", got);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("mismatch exp: cv=%0b ch=%02h val=%0b ke=%0b ve=%0b len=%0d idx=%0d last=%0b",
                                     want.char_valid, want.out_char, want.in_value, want.key_end,
                                     want.value_end, want.field_length, want.pair_index,
                                     want.out_last);
                            $display("         got: cv=%0b ch=%02h val=%0b ke=%0b ve=%0b len=%0d idx=%0d last=%0b",
                                     got.char_valid, got.out_char, got.in_value, got.key_end,
                                     got.value_end, got.field_length, got.pair_index,
                                     got.out_last);
                        end
                    end
                end
            end
            if (in_if.valid && in_if.ready)
                decoded_q.push_back(decode_byte(in_if.payload));
        end
    end

    // returns at the accepting edge with valid still high
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid_d <= 1'b0;
            @(negedge clk);
        end
        in_valid_d <= 1'b1;
        in_word_d  <= '{in_byte: b, in_last: last};
        do
            @(posedge clk);
        while (!in_if.ready);
        bytes_sent++;
    endtask

    task automatic flush_string();
        for (int i = 0; i < pend_q.size(); i++)
            send_byte(pend_q[i], i == pend_q.size() - 1);
        pend_q.delete();
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            pend_q.push_back(s[i]);
        flush_string();
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid_d <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_plus_and_escapes();
        send_str("+%4a=%6F");
    endtask

    task automatic test_bad_hex_digits();
        send_str("%G1%4Z");
    endtask

    // escape cut by '&', then by '=' which ends the string with both ends at once
    task automatic test_separator_in_escape();
        send_str("%4&%=");
    endtask

    // '&' in a key, empty key, literal '=' in a value, trailing '&' on the last word
    task automatic test_split_rules();
        send_str("k&=a=&");
    endtask

    task automatic test_truncated_escape();
        send_str("%");
    endtask

    task automatic test_byte_extremes();
        pend_q.push_back(8'h00);
        pend_q.push_back(8'hFF);
        flush_string();
    endtask

    task automatic test_pair_saturation();
        repeat (300)
            pend_q.push_back(CHAR_AMP);
        pend_q.push_back("z");
        flush_string();
    endtask

    // no idling here: the long key doubles as the stall-free stretch
    task automatic test_long_field();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        repeat (60)
            pend_q.push_back("k");
        pend_q.push_back(CHAR_EQ);
        pend_q.push_back("v");
        flush_string();
        in_idle_pct   = 10;
        out_stall_pct = 10;
    endtask

    task automatic push_field(input int n, input bit in_val);
        repeat (n)
        begin
            case ($urandom_range(11))
                0, 1, 2, 3: pend_q.push_back(8'("a" + $urandom_range(25)));
                4:          pend_q.push_back(8'("A" + $urandom_range(25)));
                5:          pend_q.push_back(CHAR_PLUS);
                6, 7:
                begin
                    pend_q.push_back(CHAR_PCT);
                    pend_q.push_back(HEX_CHARS[$urandom_range(21)]);
                    pend_q.push_back(HEX_CHARS[$urandom_range(21)]);
                end
                8:
                begin
                    pend_q.push_back(CHAR_PCT);
                    pend_q.push_back(8'($urandom_range(255)));
                    pend_q.push_back(8'($urandom_range(255)));
                end
                9:          pend_q.push_back(in_val ? CHAR_EQ : CHAR_PCT);
                10:         pend_q.push_back(8'("0" + $urandom_range(9)));
                default:    pend_q.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic test_random_strings(input int n_bytes);
        int n_pairs;
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    pend_q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                n_pairs = $urandom_range(1, 5);
                for (int p = 0; p < n_pairs; p++)
                begin
                    if (p != 0)
                        pend_q.push_back(CHAR_AMP);
                    push_field($urandom_range(0, 6), 1'b0);
                    if ($urandom_range(9) != 0)
                    begin
                        pend_q.push_back(CHAR_EQ);
                        push_field($urandom_range(0, 6), 1'b1);
                    end
                end
                if ($urandom_range(7) == 0)
                    pend_q.push_back(CHAR_AMP);
            end
            if (pend_q.size() == 0)
                pend_q.push_back("x");
            flush_string();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plus_and_escapes();
        test_bad_hex_digits();
        test_separator_in_escape();
        test_split_rules();
        test_truncated_escape();
        test_byte_extremes();
        test_pair_saturation();
        test_long_field();
        test_random_strings(275);
        hold_until_drained();
        test_random_strings(275);

        hold_until_drained();
        repeat (6) @(posedge clk);
        if (fail_cnt == 0 && decoded_q.size() == 0)
            $display("PASS form_urlencoded_decoder");
        else
            $display("FAIL form_urlencoded_decoder");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL form_urlencoded_decoder");
        $finish;
    end

endmodule

### files.f
design/fud_pkg.sv
design/fud_stream_if.sv
design/fud_front.sv
design/fud_queue.sv
design/fud_back.sv
design/form_urlencoded_decoder.sv
tb/sv/form_urlencoded_decoder_tb.sv
